>>> rtl/fwdd_pkg.sv
// Shared types and constants for the fixed-width delta decoder.
package fwdd_pkg;

   localparam int CountBits   = 16;
   localparam int ValueBits   = 64;
   localparam int CsrDataBits = 64;
   localparam int QueueDepth  = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);

   localparam logic [0:0] CsrStartValue = 1'b0;
   localparam logic [0:0] CsrValueCount = 1'b1;

   localparam logic [1:0] StatusValue    = 2'd0;
   localparam logic [1:0] StatusReserved = 2'd1;
   localparam logic [1:0] StatusEarlyEnd = 2'd2;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       byte_last;
   } beat_type;

   typedef struct packed {
      logic [ValueBits-1:0] decoded_value;
      logic [1:0]           status;
      logic                 result_last;
   } result_type;

endpackage

>>> rtl/fwdd_byte_queue.sv
// Input side: accepts stream beats into a short queue ahead of the bit engine.
module fwdd_byte_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fwdd_pkg::beat_type  req_beat,
   output logic                head_valid,
   output fwdd_pkg::beat_type  head_beat,
   input  logic                head_pop
);

   fwdd_pkg::beat_type entry_ff [fwdd_pkg::QueueDepth];
   logic [fwdd_pkg::QueuePtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fwdd_pkg::QueuePtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fwdd_pkg::QueuePtrBits:0]   count_ff, count_in;
   logic push;
   logic pop;

   assign req_ready  = (count_ff != (fwdd_pkg::QueuePtrBits + 1)'(fwdd_pkg::QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_beat  = entry_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_beat;
      end
   end

endmodule

>>> rtl/fwdd_bit_engine.sv
// Decoding side: walks each queued byte one bit per cycle, unless stalled, and forms the results.
module fwdd_bit_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  fwdd_pkg::beat_type                  head_beat,
   output logic                                head_pop,
   input  logic [fwdd_pkg::ValueBits-1:0]      start_value,
   input  logic [fwdd_pkg::CountBits-1:0]      value_count,
   input  logic                                out_free,
   output logic                                emit_valid,
   output fwdd_pkg::result_type                emit_result
);

   typedef enum logic [2:0] {
      PH_TYPE, PH_T0_DW, PH_T1_VW, PH_T1_DW, PH_SIGNED, PH_OPT, PH_DELTAS, PH_IDLE
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic [fwdd_pkg::ValueBits-1:0]  bit_shift_ff, bit_shift_in;
   logic [6:0]                      bits_held_ff, bits_held_in;
   logic [6:0]                      value_width_ff, value_width_in;
   logic [6:0]                      delta_width_ff, delta_width_in;
   logic [fwdd_pkg::ValueBits-1:0]  previous_ff, previous_in;
   logic [fwdd_pkg::CountBits-1:0]  values_done_ff, values_done_in;
   logic [3:0]                      step_ff, step_in;

   logic                            cur_bit;
   logic [fwdd_pkg::ValueBits-1:0]  shifted;
   logic [6:0]                      held_next;
   logic [6:0]                      field_plus_one;
   logic [fwdd_pkg::ValueBits-1:0]  width_mask;
   logic [fwdd_pkg::ValueBits-1:0]  sum;
   logic [fwdd_pkg::CountBits-1:0]  count_eff;
   logic                            want_emit;
   logic                            pop_want;
   logic                            fire;
   fwdd_pkg::result_type            result;

   always_comb begin
      cur_bit        = head_beat.stream_byte[~step_ff[2:0]];
      shifted        = {bit_shift_ff[fwdd_pkg::ValueBits-2:0], cur_bit};
      held_next      = bits_held_ff + 7'd1;
      field_plus_one = {1'b0, shifted[5:0]} + 7'd1;
      width_mask     = {fwdd_pkg::ValueBits{1'b1}} >> (7'd64 - value_width_ff);
      sum            = (previous_ff + shifted) & width_mask;
      count_eff      = (value_count == '0) ? fwdd_pkg::CountBits'(1) : value_count;

      phase_in       = phase_ff;
      bit_shift_in   = shifted;
      bits_held_in   = held_next;
      value_width_in = value_width_ff;
      delta_width_in = delta_width_ff;
      previous_in    = previous_ff;
      values_done_in = values_done_ff;
      step_in        = step_ff + 4'd1;
      pop_want       = 1'b0;
      want_emit      = 1'b0;
      result         = '{decoded_value: '0, status: fwdd_pkg::StatusValue, result_last: 1'b1};

      if (step_ff[3]) begin
         want_emit    = (phase_ff != PH_IDLE);
         result.status = fwdd_pkg::StatusEarlyEnd;
         phase_in     = PH_TYPE;
         bit_shift_in = '0;
         bits_held_in = '0;
         step_in      = '0;
         pop_want     = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_TYPE: begin
               if (held_next >= 7'd2) begin
                  bit_shift_in = '0;
                  bits_held_in = '0;
                  if (shifted[1:0] == 2'd0) begin
                     value_width_in = 7'd64;
                     phase_in       = PH_T0_DW;
                  end else if (shifted[1:0] == 2'd1) begin
                     phase_in = PH_T1_VW;
                  end else begin
                     want_emit     = 1'b1;
                     result.status = fwdd_pkg::StatusReserved;
                     phase_in      = PH_IDLE;
                  end
               end
            end
            PH_T0_DW, PH_T1_VW, PH_T1_DW: begin
               if (held_next >= 7'd6) begin
                  bit_shift_in = '0;
                  bits_held_in = '0;
                  if (phase_ff == PH_T1_VW) begin
                     value_width_in = field_plus_one;
                     phase_in       = PH_T1_DW;
                  end else if (phase_ff == PH_T1_DW) begin
                     delta_width_in = field_plus_one;
                     phase_in       = PH_SIGNED;
                  end else begin
                     delta_width_in = field_plus_one;
                     previous_in    = start_value;
                     values_done_in = '0;
                     phase_in       = PH_DELTAS;
                  end
               end
            end
            PH_SIGNED: begin
               bit_shift_in = '0;
               bits_held_in = '0;
               phase_in     = PH_OPT;
            end
            PH_OPT: begin
               bit_shift_in   = '0;
               bits_held_in   = '0;
               previous_in    = start_value;
               values_done_in = '0;
               phase_in       = PH_DELTAS;
            end
            PH_DELTAS: begin
               if (held_next >= delta_width_ff) begin
                  bit_shift_in         = '0;
                  bits_held_in         = '0;
                  previous_in          = sum;
                  values_done_in       = values_done_ff + 1'b1;
                  want_emit            = 1'b1;
                  result.decoded_value = sum;
                  result.result_last   = (values_done_in >= count_eff);
                  if (values_done_in >= count_eff) begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_IDLE: begin
               bit_shift_in = bit_shift_ff;
               bits_held_in = bits_held_ff;
            end
            default: begin
               phase_in = PH_TYPE;
            end
         endcase
         if (step_ff[2:0] == 3'd7) begin
            if (head_beat.byte_last) begin
               step_in = 4'd8;
            end else begin
               step_in  = '0;
               pop_want = 1'b1;
            end
         end
      end
   end

   assign fire        = head_valid && (!want_emit || out_free);
   assign head_pop    = fire && pop_want;
   assign emit_valid  = fire && want_emit;
   assign emit_result = result;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_TYPE;
         bit_shift_ff   <= '0;
         bits_held_ff   <= '0;
         value_width_ff <= 7'd64;
         delta_width_ff <= 7'd1;
         previous_ff    <= '0;
         values_done_ff <= '0;
         step_ff        <= '0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         bit_shift_ff   <= bit_shift_in;
         bits_held_ff   <= bits_held_in;
         value_width_ff <= value_width_in;
         delta_width_ff <= delta_width_in;
         previous_ff    <= previous_in;
         values_done_ff <= values_done_in;
         step_ff        <= step_in;
      end
   end

endmodule

>>> rtl/fixed_width_delta_decoder.sv
// Top level of the fixed-width delta decoder: queue, bit engine and result register.
// The decoder takes one stream byte per beat into a four-entry queue and decodes it
// in the bit engine at one bit per cycle while it is not stalled; a byte that carries
// byte_last is followed by an end-of-stream step before it is popped. Each cycle can
// produce at most one result, which goes to a single output register. The engine stalls
// while the queue is empty or when it must emit into a still held result register. Input
// beats keep flowing into the queue while the engine works, until it is full.
// start_value is sampled when a stream header completes and value_count is read live;
// both may be written only while the decoder is idle.
module fixed_width_delta_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_stream_byte,
   input  logic                                 req_byte_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fwdd_pkg::ValueBits-1:0]       rsp_decoded_value,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_result_last,
   input  logic                                 csr_write_enable,
   input  logic [0:0]                           csr_index,
   input  logic [fwdd_pkg::CsrDataBits-1:0]     csr_write_data
);

   fwdd_pkg::beat_type              req_beat;
   fwdd_pkg::beat_type              head_beat;
   logic                            head_valid;
   logic                            head_pop;
   logic                            out_free;
   logic                            emit_valid;
   fwdd_pkg::result_type            emit_result;
   fwdd_pkg::result_type            rsp_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [fwdd_pkg::ValueBits-1:0]  start_value_ff;
   logic [fwdd_pkg::CountBits-1:0]  value_count_ff;

   assign req_beat = '{stream_byte: req_stream_byte, byte_last: req_byte_last};

   fwdd_byte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_beat   (req_beat),
      .head_valid (head_valid),
      .head_beat  (head_beat),
      .head_pop   (head_pop)
   );

   fwdd_bit_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_beat   (head_beat),
      .head_pop    (head_pop),
      .start_value (start_value_ff),
      .value_count (value_count_ff),
      .out_free    (out_free),
      .emit_valid  (emit_valid),
      .emit_result (emit_result)
   );

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = emit_valid || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         start_value_ff <= '0;
         value_count_ff <= fwdd_pkg::CountBits'(1);
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            if (csr_index == fwdd_pkg::CsrStartValue) begin
               start_value_ff <= csr_write_data;
            end else if (csr_index == fwdd_pkg::CsrValueCount) begin
               value_count_ff <= csr_write_data[fwdd_pkg::CountBits-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid) begin
         rsp_ff <= emit_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_decoded_value = rsp_ff.decoded_value;
   assign rsp_status        = rsp_ff.status;
   assign rsp_result_last   = rsp_ff.result_last;

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      emit_valid |-> (!rsp_valid_ff || rsp_ready))
      else $error("bit engine emitted while the result register was held");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != fwdd_pkg::StatusValue) |-> rsp_result_last)
      else $error("error result without result_last");

   a_error_has_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != fwdd_pkg::StatusValue) |-> (rsp_decoded_value == '0))
      else $error("error result carries a nonzero value");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      (head_pop && head_valid && !emit_valid && rsp_valid_ff && !rsp_ready)
         |=> !$stable(u_queue.rd_ptr_ff) || $past(reset))
      else $error("queue head not released after pop");

endmodule
